// File: rtl/npps_pkg.sv
package npps_pkg;

	localparam int PAGE_W     = 48;
	localparam int TIME_W     = 48;
	localparam int LAT_W      = 32;
	localparam int OCC_W      = 5;
	localparam int SRV_CFG_W  = 4;
	localparam int CAP_CFG_W  = 5;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int IN_W       = 48;
	localparam int OUT_W      = 104;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PREFETCH_ENABLE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COMPUTE_TIME    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_READ_LATENCY    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SERVERS_IN_USE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_CAPACITY = 3'd4;

	localparam logic [SRV_CFG_W-1:0] SRV_RESET = 4'd8;
	localparam logic [CAP_CFG_W-1:0] CAP_RESET = 5'd16;

	typedef struct packed {
		logic accept;     // latch page, advance clock by compute time
		logic key_next;   // look up page+1 instead of page
		logic scan_start; // restart the server scan
		logic scan_run;   // step the server scan
		logic rd_calc;    // start the read on the chosen server
		logic evict;      // drop the oldest staged entry
		logic insert;     // stage page+1
		logic hit_take;   // drop the matched entry, fetch its landing time
		logic hit_fin;    // stall until the staged page lands
		logic miss_fin;   // stall until the fresh read lands
		logic out_load;   // load the result register
	} npps_cmd_t;

	typedef struct packed {
		logic pf_en;
		logic match;
		logic scan_done;
		logic need_evict;
		logic out_free;
	} npps_status_t;

endpackage

// File: rtl/npps_ctrl.sv
module npps_ctrl import npps_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  npps_status_t st,
	output npps_cmd_t    cmd
);

	typedef enum logic [8:0] {
		ST_IDLE     = 9'b000000001,
		ST_PF_CHECK = 9'b000000010,
		ST_SCAN     = 9'b000000100,
		ST_RD_CALC  = 9'b000001000,
		ST_PF_STAGE = 9'b000010000,
		ST_DM_LOOK  = 9'b000100000,
		ST_DM_HIT   = 9'b001000000,
		ST_DM_MISS  = 9'b010000000,
		ST_DONE     = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic   ctx_pf_q, ctx_pf_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d  = state_q;
		ctx_pf_d = ctx_pf_q;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_PF_CHECK;
				end
			end
			ST_PF_CHECK: begin
				cmd.key_next = 1'b1;
				if (st.pf_en && !st.match) begin
					cmd.scan_start = 1'b1;
					ctx_pf_d       = 1'b1;
					state_d        = ST_SCAN;
				end else begin
					state_d = ST_DM_LOOK;
				end
			end
			ST_SCAN: begin
				cmd.scan_run = 1'b1;
				if (st.scan_done) begin
					state_d = ST_RD_CALC;
				end
			end
			ST_RD_CALC: begin
				cmd.rd_calc = 1'b1;
				state_d     = ctx_pf_q ? ST_PF_STAGE : ST_DM_MISS;
			end
			ST_PF_STAGE: begin
				// evict one oldest entry a cycle until a slot opens under the capacity
				if (st.need_evict) begin
					cmd.evict = 1'b1;
				end else begin
					cmd.insert = 1'b1;
					state_d    = ST_DM_LOOK;
				end
			end
			ST_DM_LOOK: begin
				if (st.match) begin
					cmd.hit_take = 1'b1;
					state_d      = ST_DM_HIT;
				end else begin
					cmd.scan_start = 1'b1;
					ctx_pf_d       = 1'b0;
					state_d        = ST_SCAN;
				end
			end
			ST_DM_HIT: begin
				cmd.hit_fin = 1'b1;
				state_d     = ST_DONE;
			end
			ST_DM_MISS: begin
				cmd.miss_fin = 1'b1;
				state_d      = ST_DONE;
			end
			ST_DONE: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ctx_pf_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			ctx_pf_q <= ctx_pf_d;
		end
	end

endmodule

// File: rtl/npps_dp.sv
module npps_dp import npps_pkg::*; #(
	parameter int BUFFER_DEPTH = 16,
	parameter int SERVER_COUNT = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [IN_W-1:0]       in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [OUT_W-1:0]      out_data,
	input  npps_cmd_t             cmd,
	output npps_status_t          st
);

	localparam int IW  = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam int CW  = $clog2(BUFFER_DEPTH + 1);
	localparam int SW  = (SERVER_COUNT > 1) ? $clog2(SERVER_COUNT) : 1;
	localparam int SCW = $clog2(SERVER_COUNT + 1);

	// configuration
	logic                 pf_en_q;
	logic [LAT_W-1:0]     comp_q;
	logic [LAT_W-1:0]     lat_q;
	logic [SRV_CFG_W-1:0] srv_use_q;
	logic [CAP_CFG_W-1:0] cap_q;

	// item context
	logic [PAGE_W-1:0] page_q;
	logic [PAGE_W-1:0] next_q;
	logic [TIME_W-1:0] clk_now_q;
	logic [TIME_W-1:0] stall_q;
	logic [TIME_W-1:0] arr_q;
	logic              hit_q, issued_q, ev_q;
	logic              out_valid_q;
	logic [OUT_W-1:0]  out_data_q;

	// staging buffer
	logic [PAGE_W-1:0] ent_page_q [BUFFER_DEPTH];
	logic [IW-1:0]     ent_rank_q [BUFFER_DEPTH];
	logic [BUFFER_DEPTH-1:0] ent_vld_q;
	logic [CW-1:0]     count_q;
	logic [TIME_W-1:0] arr_mem [BUFFER_DEPTH];
	logic [TIME_W-1:0] arr_rd_q;

	// media servers
	logic [TIME_W-1:0] srv_mem [SERVER_COUNT];
	logic [SERVER_COUNT-1:0] srv_vld_q;
	logic [TIME_W-1:0] srv_rd_q;
	logic              srv_rd_vld_q;
	logic [SCW-1:0]    scan_q;
	logic              pend_q;
	logic [SW-1:0]     pend_idx_q;
	logic [TIME_W-1:0] best_q;
	logic [SW-1:0]     best_idx_q;

	logic [PAGE_W-1:0] key;
	logic              match_found;
	logic [IW-1:0]     match_idx;
	logic [IW-1:0]     old_idx;
	logic [IW-1:0]     free_idx;
	logic              drop_en;
	logic [IW-1:0]     drop_idx;
	logic [IW-1:0]     drop_rank;
	logic [CW-1:0]     cap_eff;
	logic [SCW-1:0]    n_eff;
	logic [8:0]        cap_ext;
	logic [6:0]        srv_ext;
	logic [TIME_W-1:0] srv_val;
	logic [TIME_W-1:0] rd_start;
	logic [TIME_W-1:0] rd_done;
	logic              scan_issue;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pf_en_q   <= 1'b0;
			comp_q    <= '0;
			lat_q     <= '0;
			srv_use_q <= SRV_RESET;
			cap_q     <= CAP_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_PREFETCH_ENABLE: pf_en_q   <= cfg_data[0];
				CFG_COMPUTE_TIME:    comp_q    <= cfg_data;
				CFG_READ_LATENCY:    lat_q     <= cfg_data;
				CFG_SERVERS_IN_USE:  srv_use_q <= cfg_data[SRV_CFG_W-1:0];
				CFG_BUFFER_CAPACITY: cap_q     <= cfg_data[CAP_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp the register values to between one and the built sizes
	always_comb begin
		cap_ext = {4'b0, cap_q};
		srv_ext = {3'b0, srv_use_q};
		if (cap_ext == 9'd0) begin
			cap_eff = CW'(1);
		end else if (cap_ext > 9'(BUFFER_DEPTH)) begin
			cap_eff = CW'(BUFFER_DEPTH);
		end else begin
			cap_eff = CW'(cap_ext);
		end
		if (srv_ext == 7'd0) begin
			n_eff = SCW'(1);
		end else if (srv_ext > 7'(SERVER_COUNT)) begin
			n_eff = SCW'(SERVER_COUNT);
		end else begin
			n_eff = SCW'(srv_ext);
		end
	end

	// associative lookup, oldest and free slot, lowest index first
	assign key = cmd.key_next ? next_q : page_q;

	always_comb begin
		match_found = 1'b0;
		match_idx   = '0;
		old_idx     = '0;
		free_idx    = '0;
		for (int i = BUFFER_DEPTH - 1; i >= 0; i--) begin
			if (ent_vld_q[i] && ent_page_q[i] == key) begin
				match_found = 1'b1;
				match_idx   = IW'(i);
			end
			if (ent_vld_q[i] && ent_rank_q[i] == '0) begin
				old_idx = IW'(i);
			end
			if (!ent_vld_q[i]) begin
				free_idx = IW'(i);
			end
		end
	end

	assign drop_en   = cmd.evict || cmd.hit_take;
	assign drop_idx  = cmd.evict ? old_idx : match_idx;
	assign drop_rank = ent_rank_q[drop_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
			count_q   <= '0;
			for (int i = 0; i < BUFFER_DEPTH; i++) begin
				ent_rank_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < BUFFER_DEPTH; i++) begin
				if (cmd.insert && free_idx == IW'(i)) begin
					ent_vld_q[i]  <= 1'b1;
					ent_rank_q[i] <= count_q[IW-1:0];
				end else if (drop_en && drop_idx == IW'(i)) begin
					ent_vld_q[i]  <= 1'b0;
					ent_rank_q[i] <= '0;
				end else if (drop_en && ent_vld_q[i] && ent_rank_q[i] > drop_rank) begin
					ent_rank_q[i] <= ent_rank_q[i] - IW'(1);
				end
			end
			if (cmd.insert) begin
				count_q <= count_q + CW'(1);
			end else if (drop_en) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			ent_page_q[free_idx] <= next_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			arr_mem[free_idx] <= arr_q;
		end
		arr_rd_q <= arr_mem[match_idx];
	end

	// server free times: one read a cycle during the scan, one write per read
	assign scan_issue = cmd.scan_run && (scan_q < n_eff);

	always_ff @(posedge clk) begin
		if (cmd.rd_calc) begin
			srv_mem[best_idx_q] <= rd_done;
		end
		srv_rd_q <= srv_mem[scan_q[SW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			srv_vld_q    <= '0;
			srv_rd_vld_q <= 1'b0;
		end else begin
			if (cmd.rd_calc) begin
				srv_vld_q[best_idx_q] <= 1'b1;
			end
			srv_rd_vld_q <= srv_vld_q[scan_q[SW-1:0]];
		end
	end

	assign srv_val  = srv_rd_vld_q ? srv_rd_q : '0;
	assign rd_start = (best_q > clk_now_q) ? best_q : clk_now_q;
	assign rd_done  = rd_start + {16'b0, lat_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q     <= '0;
			pend_q     <= 1'b0;
			pend_idx_q <= '0;
			best_idx_q <= '0;
		end else if (cmd.scan_start) begin
			scan_q <= '0;
			pend_q <= 1'b0;
		end else if (cmd.scan_run) begin
			pend_q     <= scan_issue;
			pend_idx_q <= scan_q[SW-1:0];
			if (scan_issue) begin
				scan_q <= scan_q + SCW'(1);
			end
			if (pend_q && (pend_idx_q == '0 || srv_val < best_q)) begin
				best_idx_q <= pend_idx_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_run && pend_q && (pend_idx_q == '0 || srv_val < best_q)) begin
			best_q <= srv_val;
		end
		if (cmd.accept) begin
			page_q <= in_data[PAGE_W-1:0];
			next_q <= in_data[PAGE_W-1:0] + PAGE_W'(1);
		end
		if (cmd.rd_calc) begin
			arr_q <= rd_done;
		end
	end

	// running clock and per-item flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_now_q <= '0;
			stall_q   <= '0;
			hit_q     <= 1'b0;
			issued_q  <= 1'b0;
			ev_q      <= 1'b0;
		end else begin
			if (cmd.accept) begin
				clk_now_q <= clk_now_q + {16'b0, comp_q};
				stall_q   <= '0;
				hit_q     <= 1'b0;
				issued_q  <= 1'b0;
				ev_q      <= 1'b0;
			end
			if (cmd.evict) begin
				ev_q <= 1'b1;
			end
			if (cmd.insert) begin
				issued_q <= 1'b1;
			end
			if (cmd.hit_take) begin
				hit_q <= 1'b1;
			end
			if (cmd.hit_fin && arr_rd_q > clk_now_q) begin
				stall_q   <= arr_rd_q - clk_now_q;
				clk_now_q <= arr_rd_q;
			end
			if (cmd.miss_fin) begin
				stall_q   <= arr_q - clk_now_q;
				clk_now_q <= arr_q;
			end
		end
	end

	// result register: holds until the request is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q <= {OCC_W'(count_q), clk_now_q, stall_q, ev_q, issued_q, hit_q};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign st.pf_en      = pf_en_q;
	assign st.match      = match_found;
	assign st.scan_done  = (scan_q == n_eff) && !pend_q;
	assign st.need_evict = (count_q >= cap_eff);
	assign st.out_free   = !out_valid_q || out_ready;

	a_count_tracks_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(ent_vld_q) == 32'(count_q))
		else $error("fill count disagrees with valid bits");

	a_insert_under_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert |-> (count_q < cap_eff))
		else $error("staging above capacity");

	a_hit_needs_match: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.hit_take |-> match_found)
		else $error("hit taken without a matching entry");

	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result register overwritten");

endmodule

// File: rtl/next_page_prefetch_staging_timer.sv
// channel   direction  handshake                     payload
// s_axis    in         s_axis_tvalid/s_axis_tready   tdata: page
// m_axis    out        m_axis_tvalid/m_axis_tready   tdata: hit .. occupancy
// cfg       in         cfg_valid/cfg_ready           cfg_index, cfg_data
//
// One item at a time: a demand hit with no media read passes ST_IDLE, ST_PF_CHECK,
// ST_DM_LOOK, ST_DM_HIT and ST_DONE. Each media read adds ST_SCAN, which steps the
// server free-time memory at one entry per cycle over servers_in_use entries, and
// ST_RD_CALC; each eviction adds a step in ST_PF_STAGE. A stalled result register holds the next item in ST_DONE only.
// arst_n clears the clock and the server and staging valid bits, and returns the configuration to its reset values.
module next_page_prefetch_staging_timer import npps_pkg::*; #(
	parameter int BUFFER_DEPTH = 16,
	parameter int SERVER_COUNT = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_W-1:0]       s_axis_tdata,  // [47:0] page
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [0] hit, [1] pf_issued, [2] evicted, [50:3] stall_time,
	// [98:51] clock_now, [103:99] occupancy
	output logic [OUT_W-1:0]      m_axis_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	npps_cmd_t    cmd;
	npps_status_t st;

	npps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.st       (st),
		.cmd      (cmd)
	);

	npps_dp #(
		.BUFFER_DEPTH (BUFFER_DEPTH),
		.SERVER_COUNT (SERVER_COUNT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (s_axis_tdata),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.cmd       (cmd),
		.st        (st)
	);

endmodule
